### rtl/rmds_pkg.sv
// Shared types, constants and helpers of the radio module discovery sequencer.
package rmds_pkg;

  // Table size and front queue depth
  localparam int RMDS_MAX_SLOTS = 16;
  localparam int RMDS_QDEPTH    = 2;

  // Register reset values
  localparam logic [15:0] BOOT_DELAY_RST     = 16'd3000;
  localparam logic [15:0] HEARTBEAT_RST      = 16'd1000;
  localparam logic [15:0] QUERY_INTERVAL_RST = 16'd500;
  localparam logic [7:0]  ATTEMPT_LIMIT_RST  = 8'd3;
  localparam logic [6:0]  CHUNKED_TYPE_RST   = 7'd9;

  // Stream packing widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_INFO  = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REQ_PING   = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_READ   = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    PH_BOOT  = 2'd0,
    PH_PING  = 2'd1,
    PH_CONN  = 2'd2,
    PH_READY = 2'd3
  } link_phase_t;

  typedef enum logic {
    BK_FETCH = 1'b0,
    BK_EXEC  = 1'b1
  } back_state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOOT_DELAY     = 3'd0,
    CFG_HEARTBEAT      = 3'd1,
    CFG_QUERY_INTERVAL = 3'd2,
    CFG_ATTEMPT_LIMIT  = 3'd3,
    CFG_CHUNKED_TYPE   = 3'd4
  } cfg_addr_t;

  typedef struct packed {
    logic [15:0] boot_delay;
    logic [15:0] heartbeat;
    logic [15:0] query_interval;
    logic [7:0]  attempt_limit;
    logic [6:0]  chunked_type;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] now_ms;
    logic        module_connected;
    logic        name_present;
    logic        info_complete;
    logic [7:0]  settings_total;
    logic [7:0]  field_id;
    logic [7:0]  chunks_left;
    logic [6:0]  value_type;
  } item_t;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] idx;
    logic [7:0] chunk;
    logic       last;
  } result_t;

  function automatic result_t make_result(req_kind_t kind, logic [7:0] idx,
                                          logic [7:0] chunk);
    result_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.chunk = chunk;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

### rtl/radio_module_discovery_sequencer_top.sv
// Top level of the radio module discovery sequencer: registers, front and back ends.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata item fields, tuser item kind
//  m_axis    out  m_axis_tvalid/tready   tdata request fields, tlast end of tick
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An item passes through fetch and then execute in the back end, so a new item
// is fetched only after the last one has executed; a tick with results holds the
// next item until its one or two requests have left the result buffer.
// Synchronous reset clears the phase, counters, slot count and both queues.
// Input stalls only when the two-entry front queue is full; cfg is always ready.
module radio_module_discovery_sequencer_top #(
  parameter int MAX_SLOTS = rmds_pkg::RMDS_MAX_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms[31:0], module_connected[32], name_present[33], info_complete[34],
  // settings_total[42:35], field_id[50:43], chunks_left[58:51],
  // value_type[65:59], zero[71:66]
  input  logic [rmds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // request_kind[1:0], read_index[9:2], read_chunk[17:10], zero[23:18]
  output logic [rmds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rmds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rmds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmds_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;
  result_t res;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_delay     <= BOOT_DELAY_RST;
      cfg.heartbeat      <= HEARTBEAT_RST;
      cfg.query_interval <= QUERY_INTERVAL_RST;
      cfg.attempt_limit  <= ATTEMPT_LIMIT_RST;
      cfg.chunked_type   <= CHUNKED_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOOT_DELAY:     cfg.boot_delay     <= cfg_data;
        CFG_HEARTBEAT:      cfg.heartbeat      <= cfg_data;
        CFG_QUERY_INTERVAL: cfg.query_interval <= cfg_data;
        CFG_ATTEMPT_LIMIT:  cfg.attempt_limit  <= cfg_data[7:0];
        CFG_CHUNKED_TYPE:   cfg.chunked_type   <= cfg_data[6:0];
        default:            cfg.boot_delay     <= cfg.boot_delay;
      endcase
    end
  end

  rmds_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head          (head),
    .pop           (pop)
  );

  rmds_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the request
  assign m_axis_tdata = {6'd0, res.chunk, res.idx, res.kind};
  assign m_axis_tlast = res.last;

endmodule

### rtl/rmds_front.sv
// Front end: accepts stream transactions, drops unused kinds, queues the rest.
module rmds_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rmds_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  output rmds_pkg::q_head_t               head,
  input  logic                            pop
);
  import rmds_pkg::*;

  localparam int QPW = (RMDS_QDEPTH > 1) ? $clog2(RMDS_QDEPTH) : 1;
  localparam int QCW = $clog2(RMDS_QDEPTH + 1);

  item_t          q_mem [RMDS_QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  item_t in_item;
  logic  kind_ok;
  logic  push;
  logic  do_pop;

  // Classify the kind and unpack the fields
  always_comb begin
    kind_ok = 1'b0;
    in_item.cmd = CMD_TICK;
    unique case (s_axis_tuser)
      CMD_TICK: begin
        kind_ok = 1'b1;
        in_item.cmd = CMD_TICK;
      end
      CMD_INFO: begin
        kind_ok = 1'b1;
        in_item.cmd = CMD_INFO;
      end
      CMD_REPLY: begin
        kind_ok = 1'b1;
        in_item.cmd = CMD_REPLY;
      end
      default: kind_ok = 1'b0;
    endcase
    in_item.now_ms           = s_axis_tdata[31:0];
    in_item.module_connected = s_axis_tdata[32];
    in_item.name_present     = s_axis_tdata[33];
    in_item.info_complete    = s_axis_tdata[34];
    in_item.settings_total   = s_axis_tdata[42:35];
    in_item.field_id         = s_axis_tdata[50:43];
    in_item.chunks_left      = s_axis_tdata[58:51];
    in_item.value_type       = s_axis_tdata[65:59];
  end

  assign s_axis_tready = (count != QCW'(RMDS_QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready && kind_ok;
  assign do_pop        = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(RMDS_QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(RMDS_QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the queued item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/rmds_back.sv
// Back end: link phases, read pacing, slot table and result buffer.
module rmds_back #(
  parameter int MAX_SLOTS = rmds_pkg::RMDS_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  rmds_pkg::cfg_t    cfg,
  input  rmds_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rmds_pkg::result_t out_res
);
  import rmds_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  back_state_t bstate, bstate_next;
  item_t       work;

  link_phase_t phase, phase_next;
  logic [31:0] last_hb, last_hb_next;
  logic [31:0] last_q, last_q_next;
  logic [7:0]  sidx, sidx_next;
  logic [7:0]  chunk, chunk_next;
  logic [7:0]  attempts, attempts_next;
  logic [7:0]  total, total_next;
  logic        active, active_next;
  logic        named, named_next;
  logic [CNT_W-1:0] slot_count, slot_count_next;

  logic [7:0] slot_ids   [MAX_SLOTS];
  logic [6:0] slot_types [MAX_SLOTS];

  result_t o0, o1;
  logic    o0_valid, o1_valid;

  result_t r0, r1;
  logic    v0, v1;

  logic             fetch_now, exec_now;
  logic             hit, full, reply_ok, is_reply;
  logic [IDX_W-1:0] hit_idx, sel;
  logic [6:0]       cur_type;
  logic             slot_alloc, type_wr;
  logic             hb_due, q_due;
  logic [7:0]       att_inc;

  // Sequence fetch and execute
  assign fetch_now = (bstate == BK_FETCH) && head.valid && !o0_valid && !o1_valid;
  assign exec_now  = (bstate == BK_EXEC);
  assign pop       = fetch_now;

  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      BK_FETCH: if (fetch_now) bstate_next = BK_EXEC;
      BK_EXEC:  bstate_next = BK_FETCH;
      default:  bstate_next = BK_FETCH;
    endcase
  end

  // Look up the reply's ID over all live slots, lowest match wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < slot_count) && (slot_ids[i] == work.field_id)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign full     = (slot_count == CNT_W'(MAX_SLOTS));
  assign reply_ok = hit || !full;
  assign sel      = hit ? hit_idx : slot_count[IDX_W-1:0];
  assign is_reply = exec_now && (work.cmd == CMD_REPLY);
  // A new slot starts at type zero unless this is a first chunk
  assign cur_type = (chunk == 8'd0) ? work.value_type : (hit ? slot_types[sel] : 7'd0);
  assign slot_alloc = is_reply && !hit && !full;
  assign type_wr    = is_reply && reply_ok && ((chunk == 8'd0) || !hit);

  assign hb_due  = (work.now_ms - last_hb) > {16'd0, cfg.heartbeat};
  assign q_due   = (work.now_ms - last_q) > {16'd0, cfg.query_interval};
  assign att_inc = attempts + 8'd1;

  // Work out the next state and the results of the current item
  always_comb begin
    phase_next      = phase;
    last_hb_next    = last_hb;
    last_q_next     = last_q;
    sidx_next       = sidx;
    chunk_next      = chunk;
    attempts_next   = attempts;
    total_next      = total;
    active_next     = active;
    named_next      = named;
    slot_count_next = slot_count;
    r0 = make_result(REQ_PING, 8'd0, 8'd0);
    r1 = make_result(REQ_PING, 8'd0, 8'd0);
    v0 = 1'b0;
    v1 = 1'b0;
    if (exec_now) begin
      unique case (work.cmd)
        CMD_TICK: begin
          unique case (phase)
            PH_BOOT: begin
              if (work.now_ms >= {16'd0, cfg.boot_delay}) phase_next = PH_PING;
            end
            PH_PING: begin
              if (hb_due) begin
                last_hb_next = work.now_ms;
                r0 = make_result(REQ_PING, 8'd0, 8'd0);
                v0 = 1'b1;
              end
              if (named) begin
                phase_next   = PH_CONN;
                last_hb_next = work.now_ms;
                sidx_next    = 8'd0;
                chunk_next   = 8'd0;
                active_next  = 1'b1;
                last_q_next  = work.now_ms;
                if (v0) begin
                  r1 = make_result(REQ_STATUS, 8'd0, 8'd0);
                  v1 = 1'b1;
                end else begin
                  r0 = make_result(REQ_STATUS, 8'd0, 8'd0);
                  v0 = 1'b1;
                end
              end
            end
            PH_CONN: begin
              if (hb_due) begin
                last_hb_next = work.now_ms;
                r0 = make_result(REQ_STATUS, 8'd0, 8'd0);
                v0 = 1'b1;
              end
              if (active && q_due) begin
                last_q_next = work.now_ms;
                if (sidx > total) begin
                  phase_next  = PH_READY;
                  active_next = 1'b0;
                end else begin
                  attempts_next = att_inc;
                  // Skip to the next index once the attempts run out
                  if (att_inc > cfg.attempt_limit) begin
                    chunk_next = 8'd0;
                    sidx_next  = sidx + 8'd1;
                  end
                  if (v0) begin
                    r1 = make_result(REQ_READ, sidx_next, chunk_next);
                    v1 = 1'b1;
                  end else begin
                    r0 = make_result(REQ_READ, sidx_next, chunk_next);
                    v0 = 1'b1;
                  end
                end
              end
            end
            PH_READY: begin
              if (hb_due) begin
                last_hb_next = work.now_ms;
                r0 = make_result(REQ_STATUS, 8'd0, 8'd0);
                v0 = 1'b1;
              end
            end
            default: phase_next = phase;
          endcase
          // Drop the module after this tick's requests
          if (!work.module_connected &&
              ((phase_next == PH_CONN) || (phase_next == PH_READY))) begin
            active_next     = 1'b0;
            slot_count_next = '0;
            named_next      = 1'b0;
            phase_next      = PH_PING;
          end
          if (v1) begin
            r1.last = 1'b1;
          end else if (v0) begin
            r0.last = 1'b1;
          end
        end
        CMD_INFO: begin
          named_next = work.name_present;
          if (work.info_complete) begin
            total_next      = work.settings_total;
            slot_count_next = '0;
          end
        end
        CMD_REPLY: begin
          if (reply_ok) begin
            if (slot_alloc) slot_count_next = slot_count + 1'b1;
            if (work.field_id == sidx) attempts_next = 8'd0;
            if ((cur_type == cfg.chunked_type) && (work.chunks_left != 8'd0)) begin
              chunk_next = chunk + 8'd1;
            end else begin
              chunk_next = 8'd0;
              sidx_next  = sidx + 8'd1;
            end
            last_q_next = 32'd0;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Hold control state and the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= BK_FETCH;
      phase      <= PH_BOOT;
      last_hb    <= '0;
      last_q     <= '0;
      sidx       <= '0;
      chunk      <= '0;
      attempts   <= '0;
      total      <= '0;
      active     <= 1'b0;
      named      <= 1'b0;
      slot_count <= '0;
      o0_valid   <= 1'b0;
      o1_valid   <= 1'b0;
    end else begin
      bstate     <= bstate_next;
      phase      <= phase_next;
      last_hb    <= last_hb_next;
      last_q     <= last_q_next;
      sidx       <= sidx_next;
      chunk      <= chunk_next;
      attempts   <= attempts_next;
      total      <= total_next;
      active     <= active_next;
      named      <= named_next;
      slot_count <= slot_count_next;
      if (exec_now) begin
        o0_valid <= v0;
        o1_valid <= v1;
      end else if (o0_valid && out_ready) begin
        o0_valid <= o1_valid;
        o1_valid <= 1'b0;
      end
    end
  end

  // Payload: working item, result slots and slot table
  always_ff @(posedge clk) begin
    if (fetch_now) work <= head.item;
    if (exec_now) begin
      o0 <= r0;
      o1 <= r1;
    end else if (o0_valid && out_ready) begin
      o0 <= o1;
    end
    if (slot_alloc) slot_ids[sel] <= work.field_id;
    if (type_wr) slot_types[sel] <= cur_type;
  end

  assign out_valid = o0_valid;
  assign out_res   = o0;

endmodule

### rtl/rmds_checker.sv
// Port-level checks of the discovery sequencer, bound to the top level.
module rmds_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rmds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import rmds_pkg::*;

  // A stalled request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled request changed");

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("request valid after reset");

  // Only ping, status and read requests leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("illegal request kind");

  // Pings and status requests carry zero index and chunk
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] != REQ_READ) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("nonzero index on non-read request");

endmodule

bind radio_module_discovery_sequencer_top rmds_checker u_rmds_checker (.*);
